>>> rtl/core/dda_pkg.sv
package dda_pkg;

    localparam int COORD_BITS        = 12;
    localparam int DEFAULT_FRAC_BITS = 16;
    localparam int COLOR_BITS        = 32;
    localparam int DIM_BITS          = 11;
    localparam int CFG_INDEX_BITS    = 1;
    localparam int CFG_DATA_BITS     = DIM_BITS;

    localparam logic [CFG_INDEX_BITS-1:0] REG_BUFFER_WIDTH  = 1'b0;
    localparam logic [CFG_INDEX_BITS-1:0] REG_BUFFER_HEIGHT = 1'b1;

    localparam logic [DIM_BITS-1:0] BUFFER_WIDTH_RESET  = 11'd200;
    localparam logic [DIM_BITS-1:0] BUFFER_HEIGHT_RESET = 11'd150;

    localparam logic KIND_START = 1'b0;
    localparam logic KIND_TICK  = 1'b1;

    typedef struct packed {
        logic                         kind;
        logic signed [COORD_BITS-1:0] start_x;
        logic signed [COORD_BITS-1:0] start_y;
        logic signed [COORD_BITS-1:0] end_x;
        logic signed [COORD_BITS-1:0] end_y;
        logic [COLOR_BITS-1:0]        line_color;
    } in_item_t;

    typedef struct packed {
        logic signed [COORD_BITS-1:0] pixel_x;
        logic signed [COORD_BITS-1:0] pixel_y;
        logic [COLOR_BITS-1:0]        pixel_color;
        logic                         write_enable;
        logic                         last;
    } out_item_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_DIVIDE,
        ST_ACTIVE
    } state_t;

    typedef struct packed {
        logic load;
        logic div_step;
        logic emit;
    } cmd_t;

    typedef struct packed {
        logic n_zero;
        logic div_last;
        logic steps_one;
        logic out_blocked;
    } status_t;

endpackage

>>> rtl/core/dda_ctrl.sv
module dda_ctrl
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    input  logic             in_kind,
    output logic             in_stall,
    input  dda_pkg::status_t status,
    output dda_pkg::cmd_t    cmd
);
    import dda_pkg::*;

    state_t state_reg;
    state_t state_next;
    logic   accept;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        in_stall     = (state_reg == ST_DIVIDE) || status.out_blocked;
        accept       = in_valid && !in_stall;
        cmd.load     = accept && (in_kind == KIND_START);
        cmd.emit     = accept && (in_kind == KIND_TICK) && (state_reg == ST_ACTIVE);
        cmd.div_step = (state_reg == ST_DIVIDE);
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE, ST_ACTIVE:
            begin
                if (in_valid && !in_stall && (in_kind == KIND_START))
                begin
                    state_next = status.n_zero ? ST_IDLE : ST_DIVIDE;
                end
                else if (in_valid && !in_stall && (in_kind == KIND_TICK)
                         && (state_reg == ST_ACTIVE) && status.steps_one)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_DIVIDE:
            begin
                if (status.div_last)
                begin
                    state_next = ST_ACTIVE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

>>> rtl/core/dda_datapath.sv
module dda_datapath
#(
    parameter int FRAC_BITS = dda_pkg::DEFAULT_FRAC_BITS
)
(
    input  logic                                clk,
    input  logic                                rst_n,
    input  dda_pkg::in_item_t                   in_item,
    output dda_pkg::out_item_t                  out_item,
    output logic                                out_valid,
    input  logic                                out_stall,
    input  logic                                cfg_write_enable,
    input  logic [dda_pkg::CFG_INDEX_BITS-1:0]  cfg_index,
    input  logic [dda_pkg::CFG_DATA_BITS-1:0]   cfg_data,
    input  dda_pkg::cmd_t                       cmd,
    output dda_pkg::status_t                    status
);
    import dda_pkg::*;

    localparam int CW    = COORD_BITS;
    localparam int DW    = CW + 1;
    localparam int RW    = CW + 1;
    localparam int QW    = FRAC_BITS + 1;
    localparam int SW    = FRAC_BITS + 2;
    localparam int PW    = CW + 1 + FRAC_BITS;
    localparam int CNT_W = $clog2(FRAC_BITS + 1);
    localparam int CMPW  = ((CW > DIM_BITS) ? CW : DIM_BITS) + 1;

    logic [DIM_BITS-1:0]   width_reg;
    logic [DIM_BITS-1:0]   height_reg;

    logic signed [PW-1:0]  pos_x_reg;
    logic signed [PW-1:0]  pos_y_reg;
    logic signed [SW-1:0]  step_x_reg;
    logic signed [SW-1:0]  step_y_reg;
    logic [CW-1:0]         steps_left_reg;
    logic [COLOR_BITS-1:0] color_reg;
    logic [CW-1:0]         n_reg;
    logic [RW-1:0]         rem_x_reg;
    logic [RW-1:0]         rem_y_reg;
    logic [QW-1:0]         q_x_reg;
    logic [QW-1:0]         q_y_reg;
    logic                  neg_x_reg;
    logic                  neg_y_reg;
    logic [CNT_W-1:0]      cnt_reg;
    logic                  out_valid_reg;
    logic                  out_valid_next;
    out_item_t             out_item_reg;

    logic signed [DW-1:0]  dx;
    logic signed [DW-1:0]  dy;
    logic [DW-1:0]         adx_full;
    logic [DW-1:0]         ady_full;
    logic [CW-1:0]         adx;
    logic [CW-1:0]         ady;
    logic [CW-1:0]         n_new;

    logic                  bit_x;
    logic                  bit_y;
    logic [RW-1:0]         sub_x;
    logic [RW-1:0]         sub_y;
    logic [QW-1:0]         q_x_next;
    logic [QW-1:0]         q_y_next;
    logic signed [SW-1:0]  step_x_new;
    logic signed [SW-1:0]  step_y_new;

    logic signed [CW:0]    int_x;
    logic signed [CW:0]    int_y;
    logic                  in_bounds;
    logic [CMPW-1:0]       cmp_x;
    logic [CMPW-1:0]       cmp_y;

    always_comb
    begin
        dx = $signed({in_item.end_x[CW-1], in_item.end_x})
           - $signed({in_item.start_x[CW-1], in_item.start_x});
        dy = $signed({in_item.end_y[CW-1], in_item.end_y})
           - $signed({in_item.start_y[CW-1], in_item.start_y});
        adx_full = dx[DW-1] ? DW'(-dx) : DW'(dx);
        ady_full = dy[DW-1] ? DW'(-dy) : DW'(dy);
        adx   = adx_full[CW-1:0];
        ady   = ady_full[CW-1:0];
        n_new = (adx >= ady) ? adx : ady;
    end

    always_comb
    begin
        bit_x    = (rem_x_reg >= {1'b0, n_reg});
        bit_y    = (rem_y_reg >= {1'b0, n_reg});
        sub_x    = bit_x ? (rem_x_reg - {1'b0, n_reg}) : rem_x_reg;
        sub_y    = bit_y ? (rem_y_reg - {1'b0, n_reg}) : rem_y_reg;
        q_x_next = {q_x_reg[QW-2:0], bit_x};
        q_y_next = {q_y_reg[QW-2:0], bit_y};
        step_x_new = neg_x_reg ? -$signed({1'b0, q_x_next}) : $signed({1'b0, q_x_next});
        step_y_new = neg_y_reg ? -$signed({1'b0, q_y_next}) : $signed({1'b0, q_y_next});
    end

    always_comb
    begin
        int_x = pos_x_reg[PW-1:FRAC_BITS]
              + $signed({{CW{1'b0}}, pos_x_reg[PW-1] && (|pos_x_reg[FRAC_BITS-1:0])});
        int_y = pos_y_reg[PW-1:FRAC_BITS]
              + $signed({{CW{1'b0}}, pos_y_reg[PW-1] && (|pos_y_reg[FRAC_BITS-1:0])});
        cmp_x  = CMPW'(int_x[CW-1:0]);
        cmp_y  = CMPW'(int_y[CW-1:0]);
        in_bounds = !int_x[CW] && !int_y[CW]
                 && (cmp_x < CMPW'(width_reg)) && (cmp_y < CMPW'(height_reg));
    end

    always_comb
    begin
        status.n_zero      = (n_new == '0);
        status.div_last    = (cnt_reg == '0);
        status.steps_one   = (steps_left_reg == CW'(1));
        status.out_blocked = out_valid_reg && out_stall;
        out_valid_next     = cmd.emit ? 1'b1 : (out_stall ? out_valid_reg : 1'b0);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg      <= BUFFER_WIDTH_RESET;
            height_reg     <= BUFFER_HEIGHT_RESET;
            out_valid_reg  <= 1'b0;
            cnt_reg        <= '0;
            steps_left_reg <= '0;
        end
        else
        begin
            if (cfg_write_enable)
            begin
                case (cfg_index)
                    REG_BUFFER_WIDTH:  width_reg  <= cfg_data;
                    REG_BUFFER_HEIGHT: height_reg <= cfg_data;
                    default:           width_reg  <= width_reg;
                endcase
            end
            out_valid_reg <= out_valid_next;
            if (cmd.load)
            begin
                cnt_reg        <= CNT_W'(FRAC_BITS);
                steps_left_reg <= n_new;
            end
            else
            begin
                if (cmd.div_step && (cnt_reg != '0))
                begin
                    cnt_reg <= cnt_reg - CNT_W'(1);
                end
                if (cmd.emit)
                begin
                    steps_left_reg <= steps_left_reg - CW'(1);
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            pos_x_reg  <= $signed({in_item.start_x[CW-1], in_item.start_x, {FRAC_BITS{1'b0}}});
            pos_y_reg  <= $signed({in_item.start_y[CW-1], in_item.start_y, {FRAC_BITS{1'b0}}});
            color_reg  <= in_item.line_color;
            n_reg      <= n_new;
            rem_x_reg  <= {1'b0, adx};
            rem_y_reg  <= {1'b0, ady};
            neg_x_reg  <= dx[DW-1];
            neg_y_reg  <= dy[DW-1];
            q_x_reg    <= '0;
            q_y_reg    <= '0;
        end
        else if (cmd.div_step)
        begin
            rem_x_reg <= {sub_x[CW-1:0], 1'b0};
            rem_y_reg <= {sub_y[CW-1:0], 1'b0};
            q_x_reg   <= q_x_next;
            q_y_reg   <= q_y_next;
            if (cnt_reg == '0)
            begin
                step_x_reg <= step_x_new;
                step_y_reg <= step_y_new;
            end
        end
        else if (cmd.emit)
        begin
            pos_x_reg <= pos_x_reg + $signed({{(PW-SW){step_x_reg[SW-1]}}, step_x_reg});
            pos_y_reg <= pos_y_reg + $signed({{(PW-SW){step_y_reg[SW-1]}}, step_y_reg});
        end

        if (cmd.emit)
        begin
            out_item_reg.pixel_x      <= int_x[CW-1:0];
            out_item_reg.pixel_y      <= int_y[CW-1:0];
            out_item_reg.pixel_color  <= color_reg;
            out_item_reg.write_enable <= in_bounds;
            out_item_reg.last         <= (steps_left_reg == CW'(1));
        end
    end

    assign out_valid = out_valid_reg;
    assign out_item  = out_item_reg;

endmodule

>>> rtl/core/dda_line_pixel_generator.sv
// Line rasteriser using a digital differential analyser. A start transfer loads the endpoints
// and colour; the two fixed-point increments are then formed by two restoring dividers
// working side by side, each producing one quotient bit per cycle, so the input is stalled
// while the division runs before ticks are taken. Each tick transfer then yields one pixel
// per clock through the output register when the output is not stalled; that register holds
// off input only while a result waits under stall. A zero-length line needs no division and
// is done at once.
module dda_line_pixel_generator
#(
    parameter int FRAC_BITS = dda_pkg::DEFAULT_FRAC_BITS
)
(
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    output logic                                in_stall,
    input  dda_pkg::in_item_t                   in_item,
    output logic                                out_valid,
    input  logic                                out_stall,
    output dda_pkg::out_item_t                  out_item,
    input  logic                                cfg_write_enable,
    input  logic [dda_pkg::CFG_INDEX_BITS-1:0]  cfg_index,
    input  logic [dda_pkg::CFG_DATA_BITS-1:0]   cfg_data
);
    import dda_pkg::*;

    cmd_t    cmd;
    status_t status;

    dda_ctrl u_ctrl
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_kind  (in_item.kind),
        .in_stall (in_stall),
        .status   (status),
        .cmd      (cmd)
    );

    dda_datapath
    #(
        .FRAC_BITS (FRAC_BITS)
    )
    u_datapath
    (
        .clk              (clk),
        .rst_n            (rst_n),
        .in_item          (in_item),
        .out_item         (out_item),
        .out_valid        (out_valid),
        .out_stall        (out_stall),
        .cfg_write_enable (cfg_write_enable),
        .cfg_index        (cfg_index),
        .cfg_data         (cfg_data),
        .cmd              (cmd),
        .status           (status)
    );

endmodule
